// ===== design/fbrc_pkg.sv =====
// ----------------------------------------------------------------------------
// fbrc_pkg
// Shared constants and types for the framed byte receiver with checksum.
// ----------------------------------------------------------------------------
package fbrc_pkg;

   localparam int PayloadBytesRaw = 4;
   localparam int StoreDepth      = 4;
   localparam int PayloadLen      = (PayloadBytesRaw < 1) ? 1 :
                                    (PayloadBytesRaw > StoreDepth) ? StoreDepth :
                                    PayloadBytesRaw;

   localparam int ByteW    = 8;
   localparam int WordW    = ByteW * StoreDepth;
   localparam int IndexW   = 3;
   localparam int SlotW    = $clog2(StoreDepth);
   localparam int CsrIdxW  = 2;

   localparam logic [ByteW-1:0] StartReset = 8'hAA;
   localparam logic [ByteW-1:0] StopReset  = 8'hFF;

   localparam logic [CsrIdxW-1:0] RegStartByte = 2'd0;
   localparam logic [CsrIdxW-1:0] RegStopByte  = 2'd1;

   localparam logic StatusMatch    = 1'b0;
   localparam logic StatusMismatch = 1'b1;

   typedef struct packed {
      logic             valid;
      logic             status;
      logic [WordW-1:0] word;
   } fbrc_result_type;

endpackage

// ===== design/fbrc_parser.sv =====
// ----------------------------------------------------------------------------
// fbrc_parser
// Frame phase tracking, payload capture and checksum compare, one byte a cycle.
// ----------------------------------------------------------------------------
module fbrc_parser
   import fbrc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             byte_valid,
   input  logic [ByteW-1:0] rx_byte,
   input  logic [ByteW-1:0] start_byte,
   input  logic [ByteW-1:0] stop_byte,
   output fbrc_result_type  result
);

   localparam logic [1:0] PhIdle    = 2'd0;
   localparam logic [1:0] PhPayload = 2'd1;
   localparam logic [1:0] PhCheck   = 2'd2;
   localparam logic [1:0] PhStop    = 2'd3;

   logic [1:0]        phase_ff, phase_in;
   logic [IndexW-1:0] index_ff, index_in;
   logic [ByteW-1:0]  store_ff [StoreDepth];
   logic [ByteW-1:0]  check_ff, check_in;
   logic              store_we;
   logic [IndexW-1:0] index_next;
   logic [ByteW-1:0]  sum;
   logic [WordW-1:0]  word;

   always_comb begin
      sum  = start_byte + stop_byte;
      word = '0;
      for (int k = 0; k < StoreDepth; k++) begin
         sum  = sum + store_ff[k];
         word = {word[WordW-ByteW-1:0], store_ff[k]};
      end
   end

   assign index_next = index_ff + 3'd1;

   always_comb begin
      phase_in = phase_ff;
      index_in = index_ff;
      check_in = check_ff;
      store_we = 1'b0;
      result   = '{valid: 1'b0, status: StatusMatch, word: word};
      if (byte_valid) begin
         case (phase_ff)
            PhIdle: begin
               if (rx_byte == start_byte) begin
                  phase_in = PhPayload;
               end
            end
            PhPayload: begin
               store_we = 1'b1;
               index_in = index_next;
               if (index_next >= IndexW'(PayloadLen)) begin
                  index_in = '0;
                  phase_in = PhCheck;
               end
            end
            PhCheck: begin
               check_in = rx_byte;
               phase_in = PhStop;
            end
            default: begin
               if (rx_byte == stop_byte) begin
                  phase_in      = PhIdle;
                  result.valid  = 1'b1;
                  result.status = (sum == check_ff) ? StatusMatch : StatusMismatch;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PhIdle;
         index_ff <= '0;
         check_ff <= '0;
         for (int k = 0; k < StoreDepth; k++) begin
            store_ff[k] <= '0;
         end
      end else begin
         phase_ff <= phase_in;
         index_ff <= index_in;
         check_ff <= check_in;
         if (store_we) begin
            store_ff[index_ff[SlotW-1:0]] <= rx_byte;
         end
      end
   end

endmodule

// ===== design/fbrc_out_stage.sv =====
// ----------------------------------------------------------------------------
// fbrc_out_stage
// Result register with a skid stage, so bytes keep flowing while a word waits.
// ----------------------------------------------------------------------------
module fbrc_out_stage
   import fbrc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  fbrc_result_type  result,
   output logic             can_accept,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [WordW-1:0] rsp_tdata,
   output logic             rsp_tuser
);

   logic             main_valid_ff, main_valid_in;
   logic             skid_valid_ff, skid_valid_in;
   logic             main_status_ff, main_status_in;
   logic [WordW-1:0] main_word_ff, main_word_in;
   logic             skid_status_ff, skid_status_in;
   logic [WordW-1:0] skid_word_ff, skid_word_in;
   logic             pop;

   assign pop        = main_valid_ff && rsp_tready;
   assign can_accept = !skid_valid_ff;

   always_comb begin
      main_valid_in  = main_valid_ff;
      skid_valid_in  = skid_valid_ff;
      main_status_in = main_status_ff;
      main_word_in   = main_word_ff;
      skid_status_in = skid_status_ff;
      skid_word_in   = skid_word_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_status_in = skid_status_ff;
            main_word_in   = skid_word_ff;
            skid_valid_in  = 1'b0;
         end
      end else if (result.valid) begin
         if (!main_valid_ff || pop) begin
            main_valid_in  = 1'b1;
            main_status_in = result.status;
            main_word_in   = result.word;
         end else begin
            skid_valid_in  = 1'b1;
            skid_status_in = result.status;
            skid_word_in   = result.word;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_status_ff <= main_status_in;
      main_word_ff   <= main_word_in;
      skid_status_ff <= skid_status_in;
      skid_word_ff   <= skid_word_in;
   end

   assign rsp_tvalid = main_valid_ff;
   assign rsp_tdata  = main_word_ff;
   assign rsp_tuser  = main_status_ff;

endmodule

// ===== design/framed_byte_receiver_checksum.sv =====
// ----------------------------------------------------------------------------
// framed_byte_receiver_checksum
// Parses start / payload / checksum / stop frames and returns the payload word
// with a checksum status.
//
//   port group  dir  contents
//   req_        in   one received byte
//   rsp_        out  payload word, checksum status
//   csr_        in   register index and byte value
//
// A byte is taken every cycle while req_tready is high; the frame result is
// registered once the stop byte is taken. The result register and skid stage
// hold up to two words; req_tready drops only while both are full. Reset is
// synchronous and resets both registers to defaults and the parser to idle.
// ----------------------------------------------------------------------------
module framed_byte_receiver_checksum
   import fbrc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [ByteW-1:0]   req_tdata,   // rx_byte
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [WordW-1:0]   rsp_tdata,   // payload_word
   output logic               rsp_tuser,   // frame_status
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [ByteW-1:0]   csr_data
);

   logic [ByteW-1:0] start_byte_ff, start_byte_in;
   logic [ByteW-1:0] stop_byte_ff, stop_byte_in;
   fbrc_result_type  result;
   logic             can_accept;

   assign csr_ready  = 1'b1;
   assign req_tready = can_accept;

   always_comb begin
      start_byte_in = start_byte_ff;
      stop_byte_in  = stop_byte_ff;
      if (csr_valid) begin
         case (csr_index)
            RegStartByte: start_byte_in = csr_data;
            RegStopByte:  stop_byte_in  = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= StartReset;
         stop_byte_ff  <= StopReset;
      end else begin
         start_byte_ff <= start_byte_in;
         stop_byte_ff  <= stop_byte_in;
      end
   end

   fbrc_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_tvalid && can_accept),
      .rx_byte    (req_tdata),
      .start_byte (start_byte_ff),
      .stop_byte  (stop_byte_ff),
      .result     (result)
   );

   fbrc_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .result     (result),
      .can_accept (can_accept),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
